### src/ctat_pkg.sv
package ctat_pkg;

	typedef struct packed {
		logic [63:0] client_hi;
		logic [63:0] client_lo;
		logic [63:0] parent_hi;
		logic [63:0] parent_lo;
		logic [31:0] seen;
	} entry_t;

	localparam int ENTRY_W = $bits(entry_t);

	localparam logic [1:0] STATUS_INSERTED  = 2'd0;
	localparam logic [1:0] STATUS_REFRESHED = 2'd1;
	localparam logic [1:0] STATUS_DROPPED   = 2'd2;
	localparam logic [1:0] STATUS_SWEPT     = 2'd3;

	localparam logic [31:0] TIMEOUT_RESET = 32'd23040;

	localparam int SLOT_W  = 7;
	localparam int COUNT_W = 8;

endpackage

### src/ctat_mem.sv
module ctat_mem #(
	parameter int DEPTH = 128,
	parameter int AW    = 7
) (
	input  logic                   clk,
	input  logic                   we,
	input  logic [AW-1:0]          waddr,
	input  ctat_pkg::entry_t       wdata,
	input  logic                   re,
	input  logic [AW-1:0]          raddr,
	output ctat_pkg::entry_t       rdata
);
	import ctat_pkg::*;

	entry_t mem_q [DEPTH];
	entry_t rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

### src/client_table_with_aging_top.sv
// Client address table with aging.
// Input channel (in_valid / in_stall) carries one item: command 0 is a client
// report (search, then refresh or append), command 1 is an aging sweep.
// Output channel (out_valid / out_stall) returns exactly one result item per
// input item, in order. The age limit must be written through cfg_wr_en /
// cfg_wr_data only while the block is idle; the block does not enforce this.
// Timing: one item at a time. A report scans the table through the single
// read port of the entry memory, one slot per cycle. A sweep reads every slot;
// an expired entry is removed by reading the last entry and writing it into
// the freed slot, which is then checked again.
// The next item is taken once the current one has moved into the output
// register, even if that register still waits on out_stall; a result that
// finds the output register still full waits until it drains.
// Reset empties the table at once (entry count to zero, no clearing pass)
// and sets the age limit to 23040.
module client_table_with_aging_top #(
	parameter int CAPACITY = 128
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic        command,
	input  logic [63:0] client_addr_hi,
	input  logic [63:0] client_addr_lo,
	input  logic [63:0] parent_addr_hi,
	input  logic [63:0] parent_addr_lo,
	input  logic [31:0] now_ticks,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [1:0]  status,
	output logic [6:0]  slot,
	output logic [7:0]  entry_count,
	output logic [7:0]  removed_count,
	input  logic        cfg_wr_en,
	input  logic [31:0] cfg_wr_data
);
	import ctat_pkg::*;

	localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CW = $clog2(CAPACITY + 1);
	localparam logic [CW-1:0] CAP = CW'(CAPACITY);
	localparam logic [CW-1:0] ONE = CW'(1);

	localparam logic [2:0] ST_IDLE    = 3'd0;
	localparam logic [2:0] ST_SRCH    = 3'd1;
	localparam logic [2:0] ST_RESOLVE = 3'd2;
	localparam logic [2:0] ST_SW_RD   = 3'd3;
	localparam logic [2:0] ST_SW_CHK  = 3'd4;
	localparam logic [2:0] ST_SW_LAST = 3'd5;
	localparam logic [2:0] ST_FIN     = 3'd6;

	logic [2:0]    state_q;
	logic [31:0]   timeout_q;
	logic [CW-1:0] count_q;
	logic [CW-1:0] idx_q;
	logic [CW-1:0] removed_q;
	logic          cmp_valid_q;
	logic [AW-1:0] cmp_idx_s1;
	logic          hit_q;
	logic [AW-1:0] hit_idx_q;

	logic [63:0]   chi_q, clo_q, phi_q, plo_q;
	logic [31:0]   now_q;

	logic [1:0]    res_status_q;
	logic [AW-1:0] res_slot_q;

	logic          out_valid_q;
	logic [1:0]    out_status_q;
	logic [6:0]    out_slot_q;
	logic [7:0]    out_count_q;
	logic [7:0]    out_removed_q;

	logic          mem_we, mem_re;
	logic [AW-1:0] mem_waddr, mem_raddr;
	entry_t        mem_wdata, mem_rdata;

	logic          match;
	logic          expired;
	logic [31:0]   age;
	logic [CW-1:0] last;
	logic          in_take;
	logic          out_free;

	logic [AW+SLOT_W-1:0]  slot_ext;
	logic [CW+COUNT_W-1:0] count_ext;
	logic [CW+COUNT_W-1:0] removed_ext;

	assign match   = (mem_rdata.client_hi == chi_q) && (mem_rdata.client_lo == clo_q);
	assign age     = now_q - mem_rdata.seen;
	assign expired = age > timeout_q;
	assign last    = count_q - ONE;
	assign in_stall = (state_q != ST_IDLE);
	assign in_take  = in_valid && (state_q == ST_IDLE);
	assign out_free = !out_valid_q || !out_stall;

	assign slot_ext    = {{SLOT_W{1'b0}}, res_slot_q};
	assign count_ext   = {{COUNT_W{1'b0}}, count_q};
	assign removed_ext = {{COUNT_W{1'b0}}, removed_q};

	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = idx_q[AW-1:0];
		mem_wdata = '{client_hi: chi_q, client_lo: clo_q, parent_hi: phi_q,
			parent_lo: plo_q, seen: now_q};
		mem_re    = 1'b0;
		mem_raddr = idx_q[AW-1:0];
		case (state_q)
			ST_SRCH: begin
				mem_re = !(cmp_valid_q && match) && (idx_q < count_q);
			end
			ST_RESOLVE: begin
				if (hit_q) begin
					mem_we    = 1'b1;
					mem_waddr = hit_idx_q;
				end else if (count_q < CAP) begin
					mem_we    = 1'b1;
					mem_waddr = count_q[AW-1:0];
				end
			end
			ST_SW_RD: begin
				mem_re = idx_q < count_q;
			end
			ST_SW_CHK: begin
				mem_re    = expired && (idx_q != last);
				mem_raddr = last[AW-1:0];
			end
			ST_SW_LAST: begin
				mem_we    = 1'b1;
				mem_wdata = mem_rdata;
			end
			default: begin
			end
		endcase
	end

	ctat_mem #(
		.DEPTH(CAPACITY),
		.AW   (AW)
	) u_mem (
		.clk  (clk),
		.we   (mem_we),
		.waddr(mem_waddr),
		.wdata(mem_wdata),
		.re   (mem_re),
		.raddr(mem_raddr),
		.rdata(mem_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			timeout_q <= TIMEOUT_RESET;
		end else if (cfg_wr_en) begin
			timeout_q <= cfg_wr_data;
		end
	end

	// latched item fields
	always_ff @(posedge clk) begin
		if (in_take) begin
			chi_q <= client_addr_hi;
			clo_q <= client_addr_lo;
			phi_q <= parent_addr_hi;
			plo_q <= parent_addr_lo;
			now_q <= now_ticks;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			count_q      <= '0;
			idx_q        <= '0;
			removed_q    <= '0;
			cmp_valid_q  <= 1'b0;
			cmp_idx_s1   <= '0;
			hit_q        <= 1'b0;
			hit_idx_q    <= '0;
			res_status_q <= STATUS_SWEPT;
			res_slot_q   <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (in_take) begin
						idx_q       <= '0;
						removed_q   <= '0;
						cmp_valid_q <= 1'b0;
						state_q     <= command ? ST_SW_RD : ST_SRCH;
					end
				end
				ST_SRCH: begin
					// compare data of the previous read while issuing the next
					if (cmp_valid_q && match) begin
						hit_q     <= 1'b1;
						hit_idx_q <= cmp_idx_s1;
						state_q   <= ST_RESOLVE;
					end else if (idx_q < count_q) begin
						cmp_valid_q <= 1'b1;
						cmp_idx_s1  <= idx_q[AW-1:0];
						idx_q       <= idx_q + ONE;
					end else if (cmp_valid_q) begin
						cmp_valid_q <= 1'b0;
					end else begin
						hit_q   <= 1'b0;
						state_q <= ST_RESOLVE;
					end
				end
				ST_RESOLVE: begin
					if (hit_q) begin
						res_status_q <= STATUS_REFRESHED;
						res_slot_q   <= hit_idx_q;
					end else if (count_q < CAP) begin
						res_status_q <= STATUS_INSERTED;
						res_slot_q   <= count_q[AW-1:0];
						count_q      <= count_q + ONE;
					end else begin
						res_status_q <= STATUS_DROPPED;
						res_slot_q   <= '0;
					end
					state_q <= ST_FIN;
				end
				ST_SW_RD: begin
					if (idx_q < count_q) begin
						state_q <= ST_SW_CHK;
					end else begin
						res_status_q <= STATUS_SWEPT;
						res_slot_q   <= '0;
						state_q      <= ST_FIN;
					end
				end
				ST_SW_CHK: begin
					if (!expired) begin
						idx_q   <= idx_q + ONE;
						state_q <= ST_SW_RD;
					end else if (idx_q == last) begin
						count_q   <= last;
						removed_q <= removed_q + ONE;
						state_q   <= ST_SW_RD;
					end else begin
						state_q <= ST_SW_LAST;
					end
				end
				ST_SW_LAST: begin
					// last entry moved into the freed slot, check it again
					count_q   <= last;
					removed_q <= removed_q + ONE;
					state_q   <= ST_SW_RD;
				end
				ST_FIN: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == ST_FIN && out_free) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_FIN && out_free) begin
			out_status_q  <= res_status_q;
			out_slot_q    <= slot_ext[SLOT_W-1:0];
			out_count_q   <= count_ext[COUNT_W-1:0];
			out_removed_q <= (res_status_q == STATUS_SWEPT) ?
				removed_ext[COUNT_W-1:0] : '0;
		end
	end

	assign out_valid     = out_valid_q;
	assign status        = out_status_q;
	assign slot          = out_slot_q;
	assign entry_count   = out_count_q;
	assign removed_count = out_removed_q;

endmodule

### dv/client_table_with_aging_top_tb.sv
`timescale 1ns / 100ps

module client_table_with_aging_top_tb;
	import ctat_pkg::*;

	localparam int TB_CAPACITY = 128;
	localparam int POOL_SIZE   = 160;
	localparam logic CMD_REPORT = 1'b0;
	localparam logic CMD_SWEEP  = 1'b1;
	localparam logic [63:0] ALL_ONES_64 = {64{1'b1}};

	typedef struct {
		logic        command;
		logic [63:0] client_hi;
		logic [63:0] client_lo;
		logic [63:0] parent_hi;
		logic [63:0] parent_lo;
		logic [31:0] now;
		bit          wait_drain;
	} table_item_t;

	typedef struct {
		logic [1:0]         status;
		logic [SLOT_W-1:0]  slot;
		logic [COUNT_W-1:0] entry_count;
		logic [COUNT_W-1:0] removed_count;
	} table_result_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic        command = 1'b0;
	logic [63:0] client_addr_hi = '0;
	logic [63:0] client_addr_lo = '0;
	logic [63:0] parent_addr_hi = '0;
	logic [63:0] parent_addr_lo = '0;
	logic [31:0] now_ticks = '0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [1:0]  status;
	logic [6:0]  slot;
	logic [7:0]  entry_count;
	logic [7:0]  removed_count;
	logic        cfg_wr_en = 1'b0;
	logic [31:0] cfg_wr_data = '0;

	client_table_with_aging_top #(
		.CAPACITY(TB_CAPACITY)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.command(command),
		.client_addr_hi(client_addr_hi),
		.client_addr_lo(client_addr_lo),
		.parent_addr_hi(parent_addr_hi),
		.parent_addr_lo(parent_addr_lo),
		.now_ticks(now_ticks),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.status(status),
		.slot(slot),
		.entry_count(entry_count),
		.removed_count(removed_count),
		.cfg_wr_en(cfg_wr_en),
		.cfg_wr_data(cfg_wr_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// shadow copy of the client table
	logic [63:0] tbl_client_hi [TB_CAPACITY];
	logic [63:0] tbl_client_lo [TB_CAPACITY];
	logic [63:0] tbl_parent_hi [TB_CAPACITY];
	logic [63:0] tbl_parent_lo [TB_CAPACITY];
	logic [31:0] tbl_seen [TB_CAPACITY];
	int          tbl_count = 0;
	logic [31:0] tbl_timeout = TIMEOUT_RESET;

	logic [63:0] pool_hi [POOL_SIZE];
	logic [63:0] pool_lo [POOL_SIZE];

	table_item_t   pending_items[$];
	table_result_t expected_results[$];

	table_item_t   cur_item;
	table_result_t drv_result;
	table_result_t mon_expect;
	bit            presenting = 0;
	int            gap_left = 0;
	int            stall_left = 0;
	int            idle_level = 1;
	logic [31:0]   tb_now = '0;

	int error_count = 0;
	int results_checked = 0;
	int n_reports = 0;
	int n_sweeps = 0;
	int n_drops = 0;
	int n_refreshes = 0;
	int n_aged_out = 0;
	int peak_fill = 0;

	function automatic logic [63:0] rand64();
		return {$urandom, $urandom};
	endfunction

	function automatic int draw_wait();
		if (idle_level == 0)
			return 0;
		return $urandom_range(6, 0);
	endfunction

	task automatic update_table(input table_item_t it, output table_result_t r);
		int          idx;
		int          i;
		int          last;
		logic [31:0] age;
		r.status = STATUS_SWEPT;
		r.slot = '0;
		r.removed_count = '0;
		if (it.command == CMD_REPORT) begin
			n_reports++;
			idx = -1;
			for (i = 0; i < tbl_count; i++)
				if (idx < 0 && tbl_client_hi[i] == it.client_hi &&
						tbl_client_lo[i] == it.client_lo)
					idx = i;
			if (idx >= 0) begin
				r.status = STATUS_REFRESHED;
				n_refreshes++;
			end else if (tbl_count < TB_CAPACITY) begin
				idx = tbl_count;
				tbl_client_hi[idx] = it.client_hi;
				tbl_client_lo[idx] = it.client_lo;
				tbl_count++;
				r.status = STATUS_INSERTED;
			end else begin
				r.status = STATUS_DROPPED;
				n_drops++;
			end
			if (idx >= 0) begin
				tbl_parent_hi[idx] = it.parent_hi;
				tbl_parent_lo[idx] = it.parent_lo;
				tbl_seen[idx] = it.now;
				r.slot = idx[SLOT_W-1:0];
			end
		end else begin
			n_sweeps++;
			i = 0;
			while (i < tbl_count) begin
				age = it.now - tbl_seen[i];
				if (age > tbl_timeout) begin
					// last entry fills the hole, same slot is checked again
					last = tbl_count - 1;
					tbl_client_hi[i] = tbl_client_hi[last];
					tbl_client_lo[i] = tbl_client_lo[last];
					tbl_parent_hi[i] = tbl_parent_hi[last];
					tbl_parent_lo[i] = tbl_parent_lo[last];
					tbl_seen[i] = tbl_seen[last];
					tbl_count--;
					r.removed_count = r.removed_count + 1'b1;
					n_aged_out++;
				end else begin
					i++;
				end
			end
		end
		r.entry_count = tbl_count[COUNT_W-1:0];
		if (tbl_count > peak_fill)
			peak_fill = tbl_count;
	endtask

	always @(posedge clk) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			presenting = 0;
			gap_left = 0;
		end else begin
			if (in_valid && !in_stall) begin
				update_table(cur_item, drv_result);
				expected_results.push_back(drv_result);
				presenting = 0;
				gap_left = draw_wait();
			end
			if (!presenting) begin
				if (gap_left > 0) begin
					gap_left--;
				end else if (pending_items.size() > 0 &&
						!(pending_items[0].wait_drain && expected_results.size() != 0)) begin
					cur_item = pending_items.pop_front();
					presenting = 1;
					command <= cur_item.command;
					client_addr_hi <= cur_item.client_hi;
					client_addr_lo <= cur_item.client_lo;
					parent_addr_hi <= cur_item.parent_hi;
					parent_addr_lo <= cur_item.parent_lo;
					now_ticks <= cur_item.now;
				end
			end
			in_valid <= presenting;
		end
	end

	task automatic compare_field(input string name, input logic [31:0] exp_v,
			input logic [31:0] act_v);
		if (exp_v !== act_v) begin
			$error("%s mismatch: expected %0d, got %0d", name, exp_v, act_v);
			error_count++;
		end
	endtask

	always @(posedge clk) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
			stall_left = 0;
		end else begin
			if (out_valid && !out_stall) begin
				if (expected_results.size() == 0) begin
					$error("result item with no item outstanding");
					error_count++;
				end else begin
					mon_expect = expected_results.pop_front();
					compare_field("status", 32'(mon_expect.status), 32'(status));
					compare_field("slot", 32'(mon_expect.slot), 32'(slot));
					compare_field("entry_count", 32'(mon_expect.entry_count),
						32'(entry_count));
					compare_field("removed_count", 32'(mon_expect.removed_count),
						32'(removed_count));
					results_checked++;
				end
				stall_left = draw_wait();
			end else if (stall_left > 0) begin
				stall_left--;
			end
			out_stall <= (stall_left != 0);
		end
	end

	task automatic queue_item(input logic cmd, input logic [63:0] chi, input logic [63:0] clo,
			input logic [63:0] phi, input logic [63:0] plo, input logic [31:0] now,
			input bit hold);
		table_item_t it;
		it.command = cmd;
		it.client_hi = chi;
		it.client_lo = clo;
		it.parent_hi = phi;
		it.parent_lo = plo;
		it.now = now;
		it.wait_drain = hold;
		pending_items.push_back(it);
	endtask

	task automatic queue_sweep(input logic [31:0] now, input bit hold);
		queue_item(CMD_SWEEP, rand64(), rand64(), rand64(), rand64(), now, hold);
	endtask

	task automatic wait_idle();
		while (pending_items.size() != 0 || presenting || expected_results.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_timeout(input logic [31:0] value);
		wait_idle();
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= value;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		cfg_wr_data <= ~value;
		tbl_timeout = value;
		@(posedge clk);
	endtask

	// fill_mode walks the address pool in order so the table overflows
	task automatic run_random_phase(input int n_items, input logic [31:0] step_max,
			input int sweep_pct, input bit fill_mode);
		int          k;
		int          pick;
		logic [31:0] now;
		bit          hold;
		for (k = 0; k < n_items; k++) begin
			tb_now = tb_now + $urandom_range(step_max, 0);
			now = tb_now;
			if ($urandom_range(99, 0) < 3)
				now = $urandom;
			hold = ($urandom_range(99, 0) < 2);
			if ($urandom_range(99, 0) < sweep_pct) begin
				queue_sweep(now, hold);
			end else if (fill_mode && k < POOL_SIZE - 15) begin
				queue_item(CMD_REPORT, pool_hi[k], pool_lo[k], rand64(), rand64(), now, hold);
			end else if ($urandom_range(99, 0) < 75) begin
				pick = $urandom_range(POOL_SIZE - 1, 0);
				queue_item(CMD_REPORT, pool_hi[pick], pool_lo[pick], rand64(), rand64(),
					now, hold);
			end else begin
				queue_item(CMD_REPORT, rand64(), rand64(), rand64(), rand64(), now, hold);
			end
		end
	endtask

	initial begin
		int          i;
		logic [31:0] rnd_timeout;

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		for (i = 0; i < POOL_SIZE; i++) begin
			pool_hi[i] = rand64();
			pool_lo[i] = rand64();
			// some neighbors differ only in the low half
			if (i % 8 == 5)
				pool_hi[i] = pool_hi[i - 1];
		end
		pool_hi[0] = '0;          pool_lo[0] = '0;
		pool_hi[1] = ALL_ONES_64; pool_lo[1] = ALL_ONES_64;
		pool_hi[2] = ALL_ONES_64; pool_lo[2] = '0;
		pool_hi[3] = '0;          pool_lo[3] = ALL_ONES_64;

		// directed, reset timeout
		queue_sweep(32'd0, 0);
		queue_item(CMD_REPORT, '0, '0, ALL_ONES_64, ALL_ONES_64, 32'd0, 0);
		queue_item(CMD_REPORT, ALL_ONES_64, ALL_ONES_64, '0, '0, 32'hFFFF_FFFF, 0);
		queue_item(CMD_REPORT, ALL_ONES_64, '0, rand64(), rand64(), 32'd10, 0);
		queue_item(CMD_REPORT, '0, ALL_ONES_64, rand64(), rand64(), 32'd10, 0);
		queue_item(CMD_REPORT, '0, '0, rand64(), rand64(), 32'd5, 0);
		// age equal to the timeout is kept, one past it goes
		queue_sweep(32'd23045, 0);
		queue_item(CMD_REPORT, '0, ALL_ONES_64, rand64(), rand64(), 32'd23045, 0);
		queue_sweep(32'd0, 0);
		queue_item(CMD_REPORT, rand64(), rand64(), rand64(), rand64(), 32'hFFFF_FFFF, 0);

		write_timeout(32'd0);
		queue_item(CMD_REPORT, rand64(), rand64(), rand64(), rand64(), 32'd100, 0);
		queue_item(CMD_REPORT, rand64(), rand64(), rand64(), rand64(), 32'd101, 0);
		queue_sweep(32'd101, 0);
		queue_sweep(32'd101, 0);

		write_timeout(32'hFFFF_FFFF);
		queue_item(CMD_REPORT, rand64(), rand64(), rand64(), rand64(), 32'd0, 0);
		queue_sweep(32'hFFFF_FFFF, 0);
		queue_sweep(32'd12345, 0);
		tb_now = 32'd12345;

		// nothing ages out, the table runs full and reports get dropped
		run_random_phase(POOL_SIZE, 32'd100, 5, 1);

		// a full table swept clean in one item
		write_timeout(32'd50);
		tb_now = tb_now + 32'd1000;
		queue_sweep(tb_now, 1);
		run_random_phase(150, 32'd5, 15, 0);

		write_timeout(TIMEOUT_RESET);
		idle_level = 0;
		run_random_phase(150, 32'd2000, 15, 0);
		wait_idle();
		idle_level = 1;

		write_timeout(32'd1);
		run_random_phase(150, 32'd2, 15, 0);

		rnd_timeout = $urandom;
		write_timeout(rnd_timeout);
		run_random_phase(150, (rnd_timeout >> 4) + 32'd1, 15, 0);

		write_timeout(32'd0);
		run_random_phase(100, 32'd1, 25, 0);

		wait_idle();
		repeat (600) @(posedge clk);

		$display("%0d results checked: %0d reports (%0d refreshes, %0d drops), %0d sweeps",
			results_checked, n_reports, n_refreshes, n_drops, n_sweeps);
		$display("peak table fill %0d of %0d, %0d entries aged out",
			peak_fill, TB_CAPACITY, n_aged_out);
		if (error_count == 0 && expected_results.size() == 0) begin
			$display("client_table_with_aging_top_tb: done, clean");
		end else begin
			$display("client_table_with_aging_top_tb: done, errors");
		end
		$finish;
	end

	initial begin
		#25_000_000;
		$display("client_table_with_aging_top_tb: done, errors");
		$finish;
	end

endmodule
